// File: src/step_pulse_generator_unit_defines.svh
// assertion macros for the step pulse generator unit
`ifndef STEP_PULSE_GENERATOR_UNIT_DEFINES_SVH
`define STEP_PULSE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SPG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spg assertion failed");
// next-cycle implication, checked out of reset
`define SPG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spg assertion failed");
`else
`define SPG_ASSERT_IMP(label, ante, cons)
`define SPG_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: src/spg_pkg.sv
// shared types and constants of the step pulse generator
package spg_pkg;

    localparam int CNT_W_DEF    = 16;
    localparam int RATE_W       = 24;
    localparam int HZ_W         = 20;
    localparam int KIND_W       = 3;
    localparam int PERIOD_OUT_W = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 24'd1000000;
    localparam int PERIOD_RESET  = 999;
    localparam int COMPARE_RESET = 500;
    localparam int RESET_W       = $clog2(PERIOD_RESET + 1);

    localparam int DIV_STEPS  = RATE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH  = 2;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SETHZ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIR    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SETHZ,
        OP_START,
        OP_STOP,
        OP_DIR,
        OP_ENABLE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [HZ_W-1:0] hz;
        logic            flag;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_src;

    typedef struct packed {
        logic                    step_out;
        logic                    dir_out;
        logic                    enable_pin_out;
        logic                    running;
        logic [PERIOD_OUT_W-1:0] period_value;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] dividend;
        logic [HZ_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [RATE_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_APPLY,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        t_back_state state;
        logic        div_busy;
        logic        res_push;
        logic        res_full;
    } t_back_status;

endpackage

// File: src/spg_front.sv
// front end: classifies incoming requests and queues them as commands
module spg_front import spg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [HZ_W-1:0]   i_hz_value,
    input  logic              i_flag_value,
    output logic              o_full,
    output t_cmd_src          o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    t_cmd                 s_cmd;
    logic                 s_wr;
    logic                 s_rd;

    // zero frequency only clears the run flag, same as stop
    always_comb begin
        s_cmd.hz   = i_hz_value;
        s_cmd.flag = i_flag_value;
        unique case (i_kind)
            KIND_TICK:   s_cmd.op = OP_TICK;
            KIND_SETHZ:  s_cmd.op = (i_hz_value == '0) ? OP_STOP : OP_SETHZ;
            KIND_START:  s_cmd.op = OP_START;
            KIND_STOP:   s_cmd.op = OP_STOP;
            KIND_DIR:    s_cmd.op = OP_DIR;
            KIND_ENABLE: s_cmd.op = OP_ENABLE;
            default:     s_cmd.op = OP_NOP;
        endcase
    end

    assign o_full    = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.cmd   = r_mem[r_rd_ptr];
    assign s_wr      = i_push && !o_full;
    assign s_rd      = i_cmd_pop && o_cmd.valid;

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= s_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (CMD_PTR_W+1)'(s_wr) - (CMD_PTR_W+1)'(s_rd);
        end
    end

endmodule

// File: src/spg_div.sv
// restoring divider, one quotient bit per cycle
module spg_div import spg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [HZ_W:0]      r_rem;
    logic [RATE_W-1:0]  r_quot;
    logic [HZ_W-1:0]    r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [HZ_W:0]      s_rem_sh;
    logic               s_fit;

    assign s_rem_sh = {r_rem[HZ_W-1:0], r_quot[RATE_W-1]};
    assign s_fit    = (s_rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= s_fit ? (s_rem_sh - {1'b0, r_div}) : s_rem_sh;
            r_quot <= {r_quot[RATE_W-2:0], s_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// File: src/spg_back.sv
// back end: executes commands on the counter state and queues the results
module spg_back import spg_pkg::*; #(
    parameter int COUNTER_WIDTH = CNT_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [RATE_W-1:0] i_cfg_wr_data,
    input  t_cmd_src          i_cmd,
    output logic              o_cmd_pop,
    output t_div_req          o_div_req,
    input  t_div_rsp          i_div_rsp,
    output t_result           o_result,
    output logic              o_empty,
    input  logic              i_pop,
    output t_back_status      o_status
);

    // state holds at least the reset period
    localparam int RW = (COUNTER_WIDTH > RESET_W) ? COUNTER_WIDTH : RESET_W;
    localparam logic [32:0] CNT_MAX = 33'((64'd1 << COUNTER_WIDTH) - 64'd1);

    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_cmd;
    logic [RATE_W-1:0] r_rate;
    logic [RW-1:0]     r_cnt;
    logic [RW-1:0]     r_period;
    logic [RW-1:0]     r_cmp;
    logic              r_run;
    logic              r_dir;
    logic              r_en_n;

    t_result              r_res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_res_wr;
    logic [RES_PTR_W-1:0] r_res_rd;
    logic [RES_PTR_W:0]   r_res_count;

    logic              s_apply;
    logic              s_res_push;
    logic              s_res_pop;
    logic              s_res_full;
    logic [RATE_W-1:0] s_q;
    logic [RATE_W-1:0] s_per_raw;
    logic              s_sat;
    logic [RW-1:0]     s_per;
    logic [RW:0]       s_cmp_sum;
    t_result           s_res;

    assign s_res_full = (r_res_count == (RES_PTR_W+1)'(RES_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = (i_cmd.cmd.op == OP_SETHZ) ? BK_DIV : BK_APPLY;
                end
            end
            BK_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = BK_APPLY;
                end
            end
            BK_APPLY: n_state = BK_EMIT;
            BK_EMIT: begin
                if (!s_res_full) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop          = (r_state == BK_IDLE) && i_cmd.valid;
        o_div_req.start    = o_cmd_pop && (i_cmd.cmd.op == OP_SETHZ);
        o_div_req.dividend = r_rate;
        o_div_req.divisor  = i_cmd.cmd.hz;
        s_apply            = (r_state == BK_APPLY);
        s_res_push         = (r_state == BK_EMIT) && !s_res_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd.cmd;
        end
    end

    // period = max(1, rate/hz) - 1, saturated; compare = (period + 1) / 2
    always_comb begin
        s_q       = (i_div_rsp.quot == '0) ? RATE_W'(1) : i_div_rsp.quot;
        s_per_raw = s_q - 1'b1;
        s_sat     = (33'(s_per_raw) > CNT_MAX);
        s_per     = s_sat ? RW'(CNT_MAX) : RW'(s_per_raw);
        s_cmp_sum = {1'b0, s_per} + (RW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RESET;
            r_cnt    <= '0;
            r_period <= RW'(PERIOD_RESET);
            r_cmp    <= RW'(COMPARE_RESET);
            r_run    <= 1'b0;
            r_dir    <= 1'b0;
            r_en_n   <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            if (s_apply) begin
                unique case (r_cmd.op)
                    OP_TICK: begin
                        if (r_run) begin
                            r_cnt <= (r_cnt >= r_period) ? '0 : r_cnt + 1'b1;
                        end
                    end
                    OP_SETHZ: begin
                        r_period <= s_per;
                        r_cmp    <= s_cmp_sum[RW:1];
                        r_cnt    <= '0;
                    end
                    OP_START:  r_run  <= 1'b1;
                    OP_STOP:   r_run  <= 1'b0;
                    OP_DIR:    r_dir  <= r_cmd.flag;
                    OP_ENABLE: r_en_n <= !r_cmd.flag;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        s_res.step_out       = (r_cnt < r_cmp);
        s_res.dir_out        = r_dir;
        s_res.enable_pin_out = r_en_n;
        s_res.running        = r_run;
        s_res.period_value   = PERIOD_OUT_W'(r_period);
    end

    // result queue
    assign s_res_pop = i_pop && !o_empty;
    assign o_empty   = (r_res_count == '0);
    assign o_result  = r_res_mem[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (s_res_push) begin
            r_res_mem[r_res_wr] <= s_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr    <= '0;
            r_res_rd    <= '0;
            r_res_count <= '0;
        end else begin
            if (s_res_push) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (s_res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            r_res_count <= r_res_count + (RES_PTR_W+1)'(s_res_push)
                         - (RES_PTR_W+1)'(s_res_pop);
        end
    end

    assign o_status.state    = r_state;
    assign o_status.div_busy = i_div_rsp.busy;
    assign o_status.res_push = s_res_push;
    assign o_status.res_full = s_res_full;

endmodule

// File: src/step_pulse_generator_unit.sv
// top level of the step pulse generator: front queue, divider and executing back end
//
// usage: each request (tick, set frequency, start, stop, set direction, set enable)
// is written like a queue push: it is taken at a clock edge with push high and
// full low. every request gives exactly one result (step, direction and enable
// pin levels, run flag and active period), read like a queue: it sits on the
// o_ ports while empty is low and leaves at an edge with pop high.
// tick_rate is written through i_cfg_wr_en / i_cfg_wr_data with the block idle.
// a taken request passes from the front queue to the back end, which applies
// it and then emits its result; set frequency first waits in the div step for
// the 24-step restoring divider. the back end works on one request at a time,
// through its idle/apply/emit sequence. the front queue holds 4 requests and the
// result queue 2, so the producer keeps pushing while results wait.
// when the consumer stalls, the back end waits in its emit step and the front
// queue fills until full rises; nothing is dropped.
// reset (synchronous, active low) empties both queues, stops the counter,
// restores period 999, compare 500, direction 0, driver disabled and
// tick_rate 1000000. no clearing pass is needed.
`include "step_pulse_generator_unit_defines.svh"

module step_pulse_generator_unit import spg_pkg::*; #(
    parameter int COUNTER_WIDTH = CNT_W_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request side
    input  logic                    push,
    output logic                    full,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic [HZ_W-1:0]         i_hz_value,
    input  logic                    i_flag_value,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  logic [RATE_W-1:0]       i_cfg_wr_data,
    // result side
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_step_out,
    output logic                    o_dir_out,
    output logic                    o_enable_pin_out,
    output logic                    o_running,
    output logic [PERIOD_OUT_W-1:0] o_period_value
);

    t_cmd_src     s_cmd;
    logic         s_cmd_pop;
    t_div_req     s_div_req;
    t_div_rsp     s_div_rsp;
    t_result      s_result;
    t_back_status s_status;

    // classify and buffer incoming requests
    spg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_kind       (i_kind),
        .i_hz_value   (i_hz_value),
        .i_flag_value (i_flag_value),
        .o_full       (full),
        .o_cmd        (s_cmd),
        .i_cmd_pop    (s_cmd_pop)
    );

    // tick_rate / hz for set frequency
    spg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    // counter state, command execution and result queue
    spg_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (s_cmd),
        .o_cmd_pop     (s_cmd_pop),
        .o_div_req     (s_div_req),
        .i_div_rsp     (s_div_rsp),
        .o_result      (s_result),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_status      (s_status)
    );

    assign o_step_out       = s_result.step_out;
    assign o_dir_out        = s_result.dir_out;
    assign o_enable_pin_out = s_result.enable_pin_out;
    assign o_running        = s_result.running;
    assign o_period_value   = s_result.period_value;

    // a full request queue always offers a command to the back end
    `SPG_ASSERT_IMP(a_full_has_cmd, full, s_cmd.valid)
    // the divider only runs while the back end waits for it
    `SPG_ASSERT_IMP(a_div_in_state, s_status.div_busy, s_status.state == BK_DIV)
    // a result is never written into a full result queue
    `SPG_ASSERT_IMP(a_push_room, s_status.res_push, !s_status.res_full)
    // a divider start is followed by a busy divider
    `SPG_ASSERT_NXT(a_div_started, s_div_req.start, s_div_rsp.busy)

endmodule
